// ----- rtl/core/aoc_pkg.sv -----
`timescale 1ns / 1ps

package aoc_pkg;

   localparam int ChanW           = 8;
   localparam int Chans           = 3;
   localparam int WeightW         = 16;
   localparam int NumW            = 24;
   localparam int QuotW           = 8;
   localparam int ChanMax         = 255;
   localparam int DivBitsPerStage = 2;
   localparam int DivStages       = QuotW / DivBitsPerStage;

   typedef logic [ChanW-1:0] chan_type;

   typedef struct packed {
      chan_type under_red;
      chan_type under_green;
      chan_type under_blue;
      chan_type under_alpha;
      chan_type over_red;
      chan_type over_green;
      chan_type over_blue;
      chan_type over_alpha;
   } req_payload_type;

   typedef struct packed {
      chan_type out_red;
      chan_type out_green;
      chan_type out_blue;
      chan_type out_alpha;
   } rsp_payload_type;

   typedef struct packed {
      chan_type [Chans-1:0]     c_over;
      chan_type [Chans-1:0]     c_under;
      logic     [WeightW-1:0]   w_over;
      logic     [WeightW-1:0]   w_under;
   } weight_type;

   typedef struct packed {
      logic [Chans-1:0][NumW-1:0]  rem;
      logic [Chans-1:0][QuotW-1:0] quot;
      logic [WeightW-1:0]          den;
      chan_type                    alpha;
      logic                        zero;
   } div_type;

   // floor(den / 255) for den <= 255*255
   function automatic chan_type alpha_of(input logic [WeightW-1:0] den);
      logic [WeightW:0] sum;
      sum = {1'b0, den} + (WeightW+1)'(den >> ChanW) + (WeightW+1)'(1);
      return sum[ChanW +: ChanW];
   endfunction

endpackage

// ----- rtl/core/aoc_req_if.sv -----
`timescale 1ns / 1ps

interface aoc_req_if;
   logic                     valid;
   logic                     ready;
   aoc_pkg::req_payload_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

// ----- rtl/core/aoc_rsp_if.sv -----
`timescale 1ns / 1ps

interface aoc_rsp_if;
   logic                     valid;
   logic                     ready;
   aoc_pkg::rsp_payload_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

// ----- rtl/core/aoc_front.sv -----
`timescale 1ns / 1ps

module aoc_front (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     in_valid,
   output logic                     in_ready,
   input  aoc_pkg::req_payload_type in_data,
   output logic                     out_valid,
   input  logic                     out_ready,
   output aoc_pkg::div_type         out_data
);

   localparam int ChanW   = aoc_pkg::ChanW;
   localparam int WeightW = aoc_pkg::WeightW;
   localparam int NumW    = aoc_pkg::NumW;
   localparam int Chans   = aoc_pkg::Chans;

   logic                s1_valid_ff;
   logic                s1_ready;
   aoc_pkg::weight_type s1_data_ff;
   aoc_pkg::weight_type s1_data_in;
   logic                s2_valid_ff;
   logic                s2_ready;
   aoc_pkg::div_type    s2_data_ff;
   aoc_pkg::div_type    s2_data_in;

   assign s1_ready = !s1_valid_ff || s2_ready;
   assign s2_ready = !s2_valid_ff || out_ready;
   assign in_ready = s1_ready;

   // stage 1: coverage weights
   always_comb begin
      logic [ChanW-1:0] inv_a1;
      inv_a1 = ChanW'(aoc_pkg::ChanMax) - in_data.over_alpha;
      s1_data_in.c_over  = {in_data.over_blue, in_data.over_green, in_data.over_red};
      s1_data_in.c_under = {in_data.under_blue, in_data.under_green, in_data.under_red};
      s1_data_in.w_over  = {in_data.over_alpha, {ChanW{1'b0}}}
                           - WeightW'(in_data.over_alpha);
      s1_data_in.w_under = WeightW'(in_data.under_alpha * inv_a1);
   end

   // stage 2: numerators, denominator, alpha
   always_comb begin
      logic [WeightW:0] den_sum;
      den_sum = {1'b0, s1_data_ff.w_over} + {1'b0, s1_data_ff.w_under};
      for (int c = 0; c < Chans; c++) begin
         s2_data_in.rem[c] = NumW'(s1_data_ff.c_over[c] * s1_data_ff.w_over)
                           + NumW'(s1_data_ff.c_under[c] * s1_data_ff.w_under);
      end
      s2_data_in.quot  = '0;
      s2_data_in.den   = den_sum[WeightW-1:0];
      s2_data_in.alpha = aoc_pkg::alpha_of(den_sum[WeightW-1:0]);
      s2_data_in.zero  = (den_sum == '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         if (s1_ready) s1_valid_ff <= in_valid;
         if (s2_ready) s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_ready && in_valid) s1_data_ff <= s1_data_in;
      if (s2_ready && s1_valid_ff) s2_data_ff <= s2_data_in;
   end

   assign out_valid = s2_valid_ff;
   assign out_data  = s2_data_ff;

endmodule

// ----- rtl/core/aoc_div_stage.sv -----
`timescale 1ns / 1ps

module aoc_div_stage #(
   parameter int StageIdx = 0
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   output logic             in_ready,
   input  aoc_pkg::div_type in_data,
   output logic             out_valid,
   input  logic             out_ready,
   output aoc_pkg::div_type out_data
);

   localparam int NumW   = aoc_pkg::NumW;
   localparam int QuotW  = aoc_pkg::QuotW;
   localparam int Chans  = aoc_pkg::Chans;
   localparam int TopBit = QuotW - 1 - StageIdx * aoc_pkg::DivBitsPerStage;

   logic             valid_ff;
   aoc_pkg::div_type data_ff;
   aoc_pkg::div_type data_in;

   assign in_ready = !valid_ff || out_ready;

   // restoring division, DivBitsPerStage quotient bits per stage
   always_comb begin
      logic [NumW-1:0] dsh;
      data_in = in_data;
      for (int j = 0; j < aoc_pkg::DivBitsPerStage; j++) begin
         dsh = NumW'(in_data.den) << (TopBit - j);
         for (int c = 0; c < Chans; c++) begin
            if (data_in.rem[c] >= dsh) begin
               data_in.rem[c]  = data_in.rem[c] - dsh;
               data_in.quot[c] = data_in.quot[c] | (QuotW'(1) << (TopBit - j));
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) data_ff <= data_in;
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

// ----- rtl/core/alpha_over_compositor_core.sv -----
`timescale 1ns / 1ps

// Porter-Duff "over" of two straight-alpha RGBA8 pixels. One transaction on
// req_bus carries the under and over pixel; one transaction on rsp_bus returns
// the composited pixel, colors truncated, alpha = floor(D/255) with
// D = a_over*255 + a_under*(255-a_over); colors are 0 when both alphas are 0.
// Fully pipelined: a new transaction is taken every cycle while rsp_bus is ready,
// and each passes through six register stages (weights, numerators, then four
// restoring divider stages of two quotient bits each). Each stage holds its own
// valid bit, so bubbles close up and the input keeps accepting while a result
// waits, until every stage is full.

module alpha_over_compositor_core (
   input  logic      clock,
   input  logic      reset,
   aoc_req_if.sink   req_bus,
   aoc_rsp_if.source rsp_bus
);

   localparam int DivStages = aoc_pkg::DivStages;

   logic             stg_valid [DivStages+1];
   logic             stg_ready [DivStages+1];
   aoc_pkg::div_type stg_data  [DivStages+1];
   aoc_pkg::div_type last;

   aoc_front u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_bus.valid),
      .in_ready  (req_bus.ready),
      .in_data   (req_bus.data),
      .out_valid (stg_valid[0]),
      .out_ready (stg_ready[0]),
      .out_data  (stg_data[0])
   );

   for (genvar s = 0; s < DivStages; s++) begin : g_div
      aoc_div_stage #(
         .StageIdx (s)
      ) u_div (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (stg_valid[s]),
         .in_ready  (stg_ready[s]),
         .in_data   (stg_data[s]),
         .out_valid (stg_valid[s+1]),
         .out_ready (stg_ready[s+1]),
         .out_data  (stg_data[s+1])
      );
   end

   assign last = stg_data[DivStages];
   assign stg_ready[DivStages] = rsp_bus.ready;

   assign rsp_bus.valid          = stg_valid[DivStages];
   assign rsp_bus.data.out_red   = last.zero ? '0 : last.quot[0];
   assign rsp_bus.data.out_green = last.zero ? '0 : last.quot[1];
   assign rsp_bus.data.out_blue  = last.zero ? '0 : last.quot[2];
   assign rsp_bus.data.out_alpha = last.alpha;

endmodule

// ----- dv/over_blend_checker.sv -----
`timescale 1ns / 1ps

module over_blend_checker (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   input  logic                     req_ready,
   input  aoc_pkg::req_payload_type req_data,
   input  logic                     rsp_valid,
   input  logic                     rsp_ready,
   input  aoc_pkg::rsp_payload_type rsp_data,
   output int                       mismatches,
   output int                       pixels_pending
);

   aoc_pkg::rsp_payload_type expected_pixels[$];

   function automatic aoc_pkg::chan_type mix_channel(input aoc_pkg::chan_type c_top,
                                                     input aoc_pkg::chan_type c_bottom,
                                                     input logic [15:0] w_top,
                                                     input logic [15:0] w_bottom,
                                                     input logic [15:0] coverage);
      logic [23:0] weighted_sum;
      if (coverage == 16'd0) begin
         return '0;
      end
      weighted_sum = 24'(c_top) * 24'(w_top) + 24'(c_bottom) * 24'(w_bottom);
      return aoc_pkg::chan_type'(weighted_sum / 24'(coverage));
   endfunction

   function automatic aoc_pkg::rsp_payload_type over_blend(input aoc_pkg::req_payload_type px);
      logic [15:0]              w_top;
      logic [15:0]              w_bottom;
      logic [15:0]              coverage;
      aoc_pkg::rsp_payload_type pix;
      w_top    = 16'(px.over_alpha) * 16'(aoc_pkg::ChanMax);
      w_bottom = 16'(px.under_alpha) * (16'(aoc_pkg::ChanMax) - 16'(px.over_alpha));
      coverage = w_top + w_bottom;
      pix.out_red   = mix_channel(px.over_red, px.under_red, w_top, w_bottom, coverage);
      pix.out_green = mix_channel(px.over_green, px.under_green, w_top, w_bottom, coverage);
      pix.out_blue  = mix_channel(px.over_blue, px.under_blue, w_top, w_bottom, coverage);
      pix.out_alpha = aoc_pkg::chan_type'(coverage / 16'(aoc_pkg::ChanMax));
      return pix;
   endfunction

   function automatic int field_errors(input string name, input aoc_pkg::chan_type exp_val,
                                       input aoc_pkg::chan_type act_val);
      if (exp_val !== act_val) begin
         $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, exp_val, act_val);
         return 1;
      end
      return 0;
   endfunction

   int                       err_total = 0;
   aoc_pkg::rsp_payload_type want;

   initial begin
      mismatches     = 0;
      pixels_pending = 0;
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (expected_pixels.size() == 0) begin
               $display("%0t: unexpected transaction, expected none, got %h", $time, rsp_data);
               err_total++;
            end else begin
               want = expected_pixels.pop_front();
               err_total += field_errors("out_red", want.out_red, rsp_data.out_red);
               err_total += field_errors("out_green", want.out_green, rsp_data.out_green);
               err_total += field_errors("out_blue", want.out_blue, rsp_data.out_blue);
               err_total += field_errors("out_alpha", want.out_alpha, rsp_data.out_alpha);
            end
         end
         if (req_valid && req_ready) begin
            expected_pixels.push_back(over_blend(req_data));
         end
      end
      mismatches     <= err_total;
      pixels_pending <= expected_pixels.size();
   end

endmodule

// ----- dv/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;

   localparam int RandomPixels = 1800;
   localparam int MaxWait      = 18;
   localparam int HoldCycles   = 120;
   localparam int IdleLimit    = 5000;
   localparam int TailCycles   = 20;

   logic clock = 1'b0;
   logic reset = 1'b1;

   aoc_req_if req_ch ();
   aoc_rsp_if rsp_ch ();

   int mismatches;
   int pixels_pending;
   int results_seen = 0;
   int idle_cycles  = 0;
   bit burst_phase  = 1'b0;
   bit rx_holding   = 1'b0;

   always #1 clock = ~clock;

   alpha_over_compositor_core dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_ch),
      .rsp_bus (rsp_ch)
   );

   over_blend_checker checker_i (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_ch.valid),
      .req_ready      (req_ch.ready),
      .req_data       (req_ch.data),
      .rsp_valid      (rsp_ch.valid),
      .rsp_ready      (rsp_ch.ready),
      .rsp_data       (rsp_ch.data),
      .mismatches     (mismatches),
      .pixels_pending (pixels_pending)
   );

   // under r,g,b,a then over r,g,b,a
   aoc_pkg::req_payload_type directed_pixels[] = '{
      64'h00000000_00000000, 64'hFFFFFFFF_FFFFFFFF, 64'hFFFFFF00_FFFFFF00,
      64'h12345600_ABCDEF00, 64'h102030FF_C0B0A0FF, 64'h102030FF_C0B0A000,
      64'h102030FF_FFFFFF80, 64'hFFFFFF01_00000001, 64'h00000001_FFFFFF00,
      64'h00000000_FFFFFF01, 64'hFFFFFFFF_000000FE, 64'h000000FF_FFFFFFFE,
      64'hFF00FF80_00FF0080, 64'h80808080_7F7F7F7F, 64'hAA55AA55_55AA55AA,
      64'h55AA55FE_AA55AA01, 64'hFFFFFFFE_FFFFFFFE, 64'h00000080_FFFFFF01,
      64'h01020340_FDFEFF40, 64'hFFFFFFFF_00000001
   };

   function automatic int draw_wait();
      if (burst_phase || rx_holding) begin
         return 0;
      end
      return $urandom_range(0, MaxWait);
   endfunction

   function automatic aoc_pkg::chan_type random_alpha();
      aoc_pkg::chan_type edge_vals[4] = '{8'd0, 8'd1, 8'd254, 8'd255};
      if ($urandom_range(0, 3) == 0) begin
         return edge_vals[$urandom_range(0, 3)];
      end
      return aoc_pkg::chan_type'($urandom_range(0, 255));
   endfunction

   function automatic aoc_pkg::req_payload_type random_pixel();
      aoc_pkg::req_payload_type px;
      px = aoc_pkg::req_payload_type'({$urandom, $urandom});
      px.under_alpha = random_alpha();
      px.over_alpha  = random_alpha();
      if ($urandom_range(0, 15) == 0) begin
         px.under_alpha = '0;
         px.over_alpha  = '0;
      end
      return px;
   endfunction

   task automatic send_pixel(input aoc_pkg::req_payload_type px);
      int gap;
      gap = draw_wait();
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.data  <= px;
      do @(posedge clock); while (!req_ch.ready);
   endtask

   // stimulus and verdict
   initial begin
      req_ch.valid <= 1'b0;
      req_ch.data  <= '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      foreach (directed_pixels[i]) begin
         send_pixel(directed_pixels[i]);
      end
      for (int i = 0; i < RandomPixels; i++) begin
         burst_phase = ((i / 150) % 3) == 1;
         send_pixel(random_pixel());
      end
      req_ch.valid <= 1'b0;
      burst_phase = 1'b0;
      @(posedge clock);
      while (pixels_pending != 0) @(posedge clock);
      repeat (TailCycles) @(posedge clock);
      if (mismatches == 0 && pixels_pending == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

   // result side, with two long hold-offs to back the pipeline up
   initial begin
      int stall;
      rsp_ch.ready <= 1'b0;
      while (reset) @(posedge clock);
      forever begin
         if (results_seen == 400 || results_seen == 1200) begin
            rx_holding = 1'b1;
            rsp_ch.ready <= 1'b0;
            repeat (HoldCycles) @(posedge clock);
            rx_holding = 1'b0;
         end else begin
            stall = burst_phase ? 0 : $urandom_range(0, MaxWait);
            if (stall > 0) begin
               rsp_ch.ready <= 1'b0;
               repeat (stall) @(posedge clock);
            end
         end
         rsp_ch.ready <= 1'b1;
         do @(posedge clock); while (!rsp_ch.valid);
         results_seen++;
      end
   end

   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IdleLimit) begin
         $display("%0t: no transaction for %0d cycles", $time, IdleLimit);
         $display("TEST FAILED");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

endmodule
